[rtl/core/pcc_pkg.sv]
`default_nettype none

package pcc_pkg;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [15:0] DELAY_INACTIVE = 16'h0AAA;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] last;
      logic [8:0] pos;
   } entry_rec_type;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_FETCH  = 7'b0000100,
      ST_UPDATE = 7'b0001000,
      ST_ROTATE = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } seq_state_type;

endpackage

`default_nettype wire

[rtl/core/pcc_entry_mem.sv]
`default_nettype none

module pcc_entry_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire pcc_pkg::entry_rec_type wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output pcc_pkg::entry_rec_type     rd_data
);

   pcc_pkg::entry_rec_type mem_ff [DEPTH];
   pcc_pkg::entry_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/pcc_map_mem.sv]
`default_nettype none

module pcc_map_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/pcc_seq.sv]
`default_nettype none

module pcc_seq #(
   parameter int NUM_ENTRIES = 16,
   parameter int MAP_SIZE    = 256,
   parameter int EW          = 4,
   parameter int MW          = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_operation,
   input  wire logic [3:0]            req_entry_index,
   input  wire logic [15:0]           req_cycle_delay,
   input  wire logic [7:0]            req_range_first,
   input  wire logic [7:0]            req_range_last,
   input  wire logic [7:0]            req_read_index,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_map_value,
   output logic                       ent_wr_en,
   output logic [EW-1:0]              ent_wr_addr,
   output pcc_pkg::entry_rec_type     ent_wr_data,
   output logic                       ent_rd_en,
   output logic [EW-1:0]              ent_rd_addr,
   input  wire pcc_pkg::entry_rec_type ent_rd_data,
   output logic                       map_wr_en,
   output logic [MW-1:0]              map_wr_addr,
   output logic [7:0]                 map_wr_data,
   output logic                       map_rd_en,
   output logic [MW-1:0]              map_rd_addr,
   input  wire logic [7:0]            map_rd_data
);

   localparam int INIT_COUNT = (NUM_ENTRIES > MAP_SIZE) ? NUM_ENTRIES : MAP_SIZE;
   localparam int CW         = $clog2(INIT_COUNT);

   pcc_pkg::seq_state_type state_ff, state_in;
   logic [CW-1:0] init_cnt_ff, init_cnt_in;
   logic [EW-1:0] ent_idx_ff, ent_idx_in;
   logic [7:0]    j_ff, j_in;
   logic [7:0]    v_ff, v_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    last_ff, last_in;
   logic          in_range_ff, in_range_in;
   logic [7:0]    result_ff, result_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_value_ff, rsp_value_in;

   logic          req_xfer;
   logic          ent_is_last;
   logic [8:0]    pos_inc;
   logic [8:0]    pos_new;
   logic [7:0]    v_dec;
   logic          out_free;

   assign req_stall   = (state_ff != pcc_pkg::ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign ent_is_last = (ent_idx_ff == EW'(NUM_ENTRIES - 1));
   assign pos_inc     = ent_rd_data.pos + 9'd1;
   assign pos_new     = (pos_inc > {1'b0, ent_rd_data.last}) ? {1'b0, ent_rd_data.first}
                                                             : pos_inc;
   assign v_dec       = v_ff - 8'd1;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      ent_idx_in   = ent_idx_ff;
      j_in         = j_ff;
      v_in         = v_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      in_range_in  = in_range_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      ent_wr_en    = 1'b0;
      ent_wr_addr  = ent_idx_ff;
      ent_wr_data  = '0;
      ent_rd_en    = 1'b0;
      ent_rd_addr  = ent_idx_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = MW'(j_ff);
      map_wr_data  = v_ff;
      map_rd_en    = 1'b0;
      map_rd_addr  = MW'(req_read_index);

      case (state_ff)
         pcc_pkg::ST_INIT: begin
            ent_wr_en   = (32'(init_cnt_ff) < NUM_ENTRIES);
            ent_wr_addr = EW'(init_cnt_ff);
            map_wr_en   = (32'(init_cnt_ff) < MAP_SIZE);
            map_wr_addr = MW'(init_cnt_ff);
            map_wr_data = 8'(init_cnt_ff);
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff == CW'(INIT_COUNT - 1)) begin
               state_in = pcc_pkg::ST_IDLE;
            end
         end
         pcc_pkg::ST_IDLE: begin
            map_rd_en = req_xfer && (req_operation == pcc_pkg::OP_READ);
            if (req_xfer) begin
               result_in = 8'd0;
               case (req_operation)
                  pcc_pkg::OP_LOAD: begin
                     ent_wr_en         = (7'(req_entry_index) < 7'(NUM_ENTRIES));
                     ent_wr_addr       = EW'(req_entry_index);
                     ent_wr_data.first = req_range_first;
                     ent_wr_data.last  = req_range_last;
                     ent_wr_data.pos   = (req_cycle_delay != 16'd0 &&
                                          req_cycle_delay != pcc_pkg::DELAY_INACTIVE)
                                         ? {1'b0, req_range_first} : 9'd0;
                     state_in          = pcc_pkg::ST_DONE;
                  end
                  pcc_pkg::OP_TICK: begin
                     ent_idx_in = '0;
                     state_in   = pcc_pkg::ST_FETCH;
                  end
                  pcc_pkg::OP_READ: begin
                     in_range_in = (32'(req_read_index) < MAP_SIZE);
                     state_in    = pcc_pkg::ST_READ;
                  end
                  default: begin
                     state_in = pcc_pkg::ST_DONE;
                  end
               endcase
            end
         end
         pcc_pkg::ST_FETCH: begin
            ent_rd_en = 1'b1;
            state_in  = pcc_pkg::ST_UPDATE;
         end
         pcc_pkg::ST_UPDATE: begin
            if (ent_rd_data.pos != 9'd0) begin
               ent_wr_en       = 1'b1;
               ent_wr_data     = ent_rd_data;
               ent_wr_data.pos = pos_new;
            end
            if (ent_rd_data.pos != 9'd0 && ent_rd_data.first <= ent_rd_data.last) begin
               j_in     = ent_rd_data.first;
               v_in     = pos_new[7:0];
               first_in = ent_rd_data.first;
               last_in  = ent_rd_data.last;
               state_in = pcc_pkg::ST_ROTATE;
            end else if (ent_is_last) begin
               state_in = pcc_pkg::ST_DONE;
            end else begin
               ent_idx_in = ent_idx_ff + 1'b1;
               state_in   = pcc_pkg::ST_FETCH;
            end
         end
         pcc_pkg::ST_ROTATE: begin
            map_wr_en = (32'(j_ff) < MAP_SIZE);
            v_in      = (v_dec < first_ff) ? last_ff : v_dec;
            j_in      = j_ff + 8'd1;
            if (j_ff == last_ff) begin
               if (ent_is_last) begin
                  state_in = pcc_pkg::ST_DONE;
               end else begin
                  ent_idx_in = ent_idx_ff + 1'b1;
                  state_in   = pcc_pkg::ST_FETCH;
               end
            end
         end
         pcc_pkg::ST_READ: begin
            result_in = in_range_ff ? map_rd_data : 8'd0;
            state_in  = pcc_pkg::ST_DONE;
         end
         pcc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               state_in     = pcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pcc_pkg::ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcc_pkg::ST_INIT;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_idx_ff   <= ent_idx_in;
      j_ff         <= j_in;
      v_ff         <= v_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      in_range_ff  <= in_range_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_map_value = rsp_value_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != pcc_pkg::ST_IDLE))
      else $error("accepted transfer did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pcc_pkg::ST_DONE))
      else $error("response raised outside completion");

   a_rotate_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcc_pkg::ST_ROTATE) |-> (j_ff >= first_ff && j_ff <= last_ff))
      else $error("rotation index left its range");

   a_rotate_value: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcc_pkg::ST_ROTATE) |-> (v_ff >= first_ff && v_ff <= last_ff))
      else $error("rotation value left its range");

endmodule

`default_nettype wire

[rtl/core/palette_color_cycler_top.sv]
// Palette color cycler: a table of 16 entries for color cycling and a shadow color-index map.
// Request channel (req_valid / req_stall) carries one operation per transfer:
//   load sets one cycle entry, tick advances all active entries and rewrites
//   the map over their ranges, read returns one map entry.
// Response channel (rsp_valid / rsp_stall) returns one rsp_map_value per
//   request, zero for load, tick and the unused operation code.
// Work per request: load writes the entry and goes to DONE; read goes through
//   READ to DONE; tick runs FETCH and UPDATE for every entry and ROTATE over
//   each active range, with one map write port taking one map entry per cycle
//   in the rotation sequencer; DONE waits under rsp_stall for the output register.
// One request is in work at a time; req_stall is high until its response is
//   placed in the output register, which holds under rsp_stall while the
//   next request is taken.
// After reset the block sweeps the map to identity and clears the cycle
//   entries with req_stall high.
`default_nettype none

module palette_color_cycler_top #(
   parameter int NUM_ENTRIES = 16,
   parameter int MAP_SIZE    = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_operation,
   input  wire logic [3:0] req_entry_index,
   input  wire logic [15:0] req_cycle_delay,
   input  wire logic [7:0] req_range_first,
   input  wire logic [7:0] req_range_last,
   input  wire logic [7:0] req_read_index,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_map_value
);

   localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int MW = $clog2(MAP_SIZE);

   logic                   ent_wr_en;
   logic [EW-1:0]          ent_wr_addr;
   pcc_pkg::entry_rec_type ent_wr_data;
   logic                   ent_rd_en;
   logic [EW-1:0]          ent_rd_addr;
   pcc_pkg::entry_rec_type ent_rd_data;
   logic                   map_wr_en;
   logic [MW-1:0]          map_wr_addr;
   logic [7:0]             map_wr_data;
   logic                   map_rd_en;
   logic [MW-1:0]          map_rd_addr;
   logic [7:0]             map_rd_data;

   pcc_seq #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .MAP_SIZE    (MAP_SIZE),
      .EW          (EW),
      .MW          (MW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_cycle_delay (req_cycle_delay),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_map_value   (rsp_map_value),
      .ent_wr_en       (ent_wr_en),
      .ent_wr_addr     (ent_wr_addr),
      .ent_wr_data     (ent_wr_data),
      .ent_rd_en       (ent_rd_en),
      .ent_rd_addr     (ent_rd_addr),
      .ent_rd_data     (ent_rd_data),
      .map_wr_en       (map_wr_en),
      .map_wr_addr     (map_wr_addr),
      .map_wr_data     (map_wr_data),
      .map_rd_en       (map_rd_en),
      .map_rd_addr     (map_rd_addr),
      .map_rd_data     (map_rd_data)
   );

   pcc_entry_mem #(
      .DEPTH (NUM_ENTRIES),
      .AW    (EW)
   ) u_entry_mem (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   pcc_map_mem #(
      .DEPTH (MAP_SIZE),
      .AW    (MW)
   ) u_map_mem (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int ENTRY_COUNT   = 16;
   localparam int MAP_DEPTH     = 256;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 115;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [1:0] OP_SPARE = 2'd3;

   class color_cycle_scoreboard;
      logic [7:0] range_lo [ENTRY_COUNT];
      logic [7:0] range_hi [ENTRY_COUNT];
      logic [8:0] position [ENTRY_COUNT];
      logic [7:0] color_map [MAP_DEPTH];
      logic [7:0] pending_map_values [$];
      int mismatches;

      function new();
         for (int e = 0; e < ENTRY_COUNT; e++) begin
            range_lo[e] = '0;
            range_hi[e] = '0;
            position[e] = '0;
         end
         for (int i = 0; i < MAP_DEPTH; i++)
            color_map[i] = i[7:0];
         mismatches = 0;
      endfunction

      function void rotate_entry(int e);
         logic [8:0] pos;
         logic [7:0] v;
         pos = position[e];
         if (pos == '0)
            return;
         pos = pos + 9'd1;
         if (pos > {1'b0, range_hi[e]})
            pos = {1'b0, range_lo[e]};
         position[e] = pos;
         if (range_lo[e] > range_hi[e])
            return;
         v = pos[7:0];
         for (int j = range_lo[e]; j <= range_hi[e]; j++) begin
            if (j < MAP_DEPTH)
               color_map[j] = v;
            v = v - 8'd1;
            if (v < range_lo[e])
               v = range_hi[e];
         end
      endfunction

      function void note_request(logic [1:0] op, logic [3:0] idx, logic [15:0] delay,
                                 logic [7:0] first, logic [7:0] last, logic [7:0] ridx);
         logic [7:0] value;
         value = '0;
         case (op)
            pcc_pkg::OP_LOAD: begin
               if (idx < ENTRY_COUNT) begin
                  range_lo[idx] = first;
                  range_hi[idx] = last;
                  if (delay != '0 && delay != pcc_pkg::DELAY_INACTIVE)
                     position[idx] = {1'b0, first};
                  else
                     position[idx] = '0;
               end
            end
            pcc_pkg::OP_TICK: begin
               for (int e = 0; e < ENTRY_COUNT; e++)
                  rotate_entry(e);
            end
            pcc_pkg::OP_READ: begin
               if (ridx < MAP_DEPTH)
                  value = color_map[ridx];
            end
            default: ;
         endcase
         pending_map_values.push_back(value);
      endfunction

      function void check_response(logic [7:0] actual);
         logic [7:0] wanted;
         if (pending_map_values.size() == 0) begin
            $error("unexpected transfer: map_value actual %0d", actual);
            mismatches++;
            return;
         end
         wanted = pending_map_values.pop_front();
         if (actual !== wanted) begin
            $error("map_value mismatch: expected %0d actual %0d", wanted, actual);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_map_values.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [3:0]  req_entry_index = '0;
   logic [15:0] req_cycle_delay = '0;
   logic [7:0]  req_range_first = '0;
   logic [7:0]  req_range_last = '0;
   logic [7:0]  req_read_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_map_value;

   int hold_requests = 0;
   int holds_done = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int stall_phase = 0;

   color_cycle_scoreboard book = new();

   palette_color_cycler_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_entry_index (req_entry_index),
      .req_cycle_delay (req_cycle_delay),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .req_read_index  (req_read_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_map_value   (rsp_map_value)
   );

   always #5 clock = ~clock;

   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            book.check_response(rsp_map_value);
         if (req_valid && !req_stall)
            book.note_request(req_operation, req_entry_index, req_cycle_delay,
                              req_range_first, req_range_last, req_read_index);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
         rsp_stall <= 1'b1;
         holds_done <= holds_done + 1;
         hold_left <= HOLD_CYCLES;
      end else begin
         stall_phase <= stall_phase + 1;
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(16, 96);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= 1'($urandom_range(0, 1));
            2: rsp_stall <= (stall_phase % 3 == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic send(logic [1:0] op, logic [3:0] idx, logic [15:0] delay,
                       logic [7:0] first, logic [7:0] last, logic [7:0] ridx);
      req_valid <= 1'b1;
      req_operation <= op;
      req_entry_index <= idx;
      req_cycle_delay <= delay;
      req_range_first <= first;
      req_range_last <= last;
      req_read_index <= ridx;
      do
         @(posedge clock);
      while (req_stall);
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [1:0]  op;
      logic [15:0] delay;
      logic [7:0]  first;
      logic [7:0]  last;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         op = pcc_pkg::OP_LOAD;
      else if (pick < 55)
         op = pcc_pkg::OP_TICK;
      else if (pick < 95)
         op = pcc_pkg::OP_READ;
      else
         op = OP_SPARE;
      pick = $urandom_range(0, 9);
      delay = (pick == 0) ? 16'h0000 :
              (pick == 1) ? pcc_pkg::DELAY_INACTIVE : 16'($urandom);
      first = ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      pick = $urandom_range(0, 19);
      if (pick == 0)
         last = 8'd255;
      else if (pick < 3)
         last = 8'($urandom);
      else
         last = (int'(first) + 7 > 255) ? 8'd255 : first + 8'($urandom_range(0, 7));
      send(op, 4'($urandom), delay, first, last, 8'($urandom));
   endtask

   initial begin
      int burst_left;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send(pcc_pkg::OP_READ, 4'h0, 16'h0000, 8'h00, 8'h00, 8'd0);
      send(pcc_pkg::OP_READ, 4'hF, 16'hFFFF, 8'hFF, 8'hFF, 8'd255);
      send(OP_SPARE, 4'hF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      send(pcc_pkg::OP_LOAD, 4'd0, pcc_pkg::DELAY_INACTIVE, 8'd5, 8'd9, 8'd0);
      send(pcc_pkg::OP_LOAD, 4'd1, 16'h0000, 8'd5, 8'd9, 8'd0);
      send(pcc_pkg::OP_LOAD, 4'd2, 16'hFFFF, 8'd0, 8'd255, 8'd0);
      send(pcc_pkg::OP_LOAD, 4'd3, 16'h0001, 8'd10, 8'd20, 8'd0);
      send(pcc_pkg::OP_LOAD, 4'd4, 16'h0AAB, 8'd15, 8'd18, 8'd0);
      send(pcc_pkg::OP_LOAD, 4'd5, 16'h8000, 8'd200, 8'd100, 8'd0);
      send(pcc_pkg::OP_LOAD, 4'd15, 16'h5555, 8'd254, 8'd255, 8'd0);
      send(pcc_pkg::OP_TICK, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd10);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd16);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd255);
      send(pcc_pkg::OP_TICK, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0);
      send(pcc_pkg::OP_TICK, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd254);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd200);
      send(pcc_pkg::OP_LOAD, 4'd6, 16'h0002, 8'd1, 8'd255, 8'd0);
      send(pcc_pkg::OP_TICK, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd1);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd128);
      send(pcc_pkg::OP_LOAD, 4'd6, 16'h0000, 8'd255, 8'd0, 8'd0);
      send(pcc_pkg::OP_TICK, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0);
      send(pcc_pkg::OP_READ, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd20);

      burst_left = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 50)
            hold_requests <= hold_requests + 1;
         if (n == 100)
            drain();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
               pause_sender($urandom_range(1, 15));
         end
         send_random_item();
         burst_left--;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
